>>> design/lpdm_pkg.sv
`timescale 1ns / 1ps

package lpdm_pkg;

  // Field widths of the stream items.
  localparam int IDX_W  = 8;
  localparam int MAG_W  = 16;
  localparam int CH_W   = 8;
  localparam int STEP_W = 9;

  // Index span that an 8-bit LED index can reach.
  localparam int IDX_SPAN = 1 << IDX_W;

  // Default number of LEDs with a held peak.
  localparam int LED_COUNT_DEF = 256;

  // Held peak after decay never exceeds PEAK_MAX, so it fits in 11 bits.
  localparam int PEAK_W = 11;
  localparam int CLAMP_W = 12;
  localparam logic [CLAMP_W-1:0] PEAK_CLAMP = 12'd2048;
  localparam logic [CLAMP_W-1:0] PEAK_DECAY = 12'd60;
  localparam logic [PEAK_W-1:0]  PEAK_MAX   = 11'd1988;

  // Divisor width and its reset value.
  localparam int DIV_W = 12;
  localparam logic [DIV_W-1:0] DIV_RESET = 12'd100;
  localparam logic [DIV_W-1:0] DIV_ONE   = 12'd1;

  // Colour register reset values.
  localparam logic [CH_W-1:0] HUE_BASE_RESET    = 8'd0;
  localparam logic [CH_W-1:0] SAT_TOP_RESET     = 8'd255;
  localparam logic [CH_W-1:0] BRIGHT_BASE_RESET = 8'd0;
  localparam logic [CH_W-1:0] STEP_RESET        = 8'd0;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LEVEL_DIVIDER = 3'd0,
    REG_HUE_BASE      = 3'd1,
    REG_HUE_STEP      = 3'd2,
    REG_SAT_TOP       = 3'd3,
    REG_SAT_STEP      = 3'd4,
    REG_BRIGHT_BASE   = 3'd5,
    REG_BRIGHT_STEP   = 3'd6
  } cfg_reg_t;

  // Packed stream words.
  localparam int S_DATA_W = IDX_W + MAG_W;
  localparam int M_DATA_W = IDX_W + 3 * CH_W;

endpackage

>>> design/lpdm_divider.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage, with a tag that
// travels alongside. Each stage holds its item until the next one can take it.
module lpdm_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpdm_pkg::PEAK_W-1:0]   in_peak,
  input  logic [lpdm_pkg::IDX_W-1:0]    in_tag,
  input  logic [lpdm_pkg::DIV_W-1:0]    divisor,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lpdm_pkg::PEAK_W-1:0]   out_level,
  output logic [lpdm_pkg::IDX_W-1:0]    out_tag
);
  import lpdm_pkg::*;

  localparam int N = PEAK_W;

  logic [N-1:0]        v;
  logic [DIV_W-1:0]    rem [N];
  logic [PEAK_W-1:0]   dq  [N];
  logic [IDX_W-1:0]    tag [N];
  logic [N:0]          rdy;

  // A stage can load when it is empty or its item moves on.
  assign rdy[N] = out_ready;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic              src_v;
    logic [DIV_W-1:0]  src_rem;
    logic [PEAK_W-1:0] src_dq;
    logic [IDX_W-1:0]  src_tag;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              ge;
    logic [DIV_W-1:0]  rem_next;
    logic [PEAK_W-1:0] dq_next;

    if (k == 0) begin : g_first
      assign src_v   = in_valid;
      assign src_rem = '0;
      assign src_dq  = in_peak;
      assign src_tag = in_tag;
    end else begin : g_rest
      assign src_v   = v[k-1];
      assign src_rem = rem[k-1];
      assign src_dq  = dq[k-1];
      assign src_tag = tag[k-1];
    end

    assign rdy[k] = !v[k] || rdy[k+1];

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
      trial    = {src_rem, src_dq[PEAK_W-1]};
      diff     = trial - {1'b0, divisor};
      ge       = (trial >= {1'b0, divisor});
      rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dq_next  = {src_dq[PEAK_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem[k] <= rem_next;
        dq[k]  <= dq_next;
        tag[k] <= src_tag;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[N-1];
  assign out_level = dq[N-1];
  assign out_tag   = tag[N-1];

endmodule

>>> design/led_peak_decay_color_mapper.sv
`timescale 1ns / 1ps

// Channel      Signals                        Item
// input        s_axis_tvalid/tready/tdata     led_index, magnitude
// output       m_axis_tvalid/tready/tdata     led_out_index, hue, saturation, brightness
// config       cfg_we, cfg_addr, cfg_wdata    one register write per cycle
//
// One item enters per cycle while nothing stalls; its result passes through the
// peak update stage, 11 divider stages at one quotient bit each and the color stage.
// The held-peak store is read on acceptance and written as the item leaves the
// peak update stage; a back-to-back item on the same LED takes the new peak by
// forwarding. Reset clears the per-LED valid bits at once, so there is no
// clearing pass.
// Each stage holds its item only while the next one is full, so bubbles close
// up and input is still taken while a finished result waits at the output.
module led_peak_decay_color_mapper #(
  parameter int LED_COUNT = lpdm_pkg::LED_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] led_index, [23:8] magnitude
  input  logic [lpdm_pkg::S_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] led_out_index, [15:8] hue, [23:16] saturation, [31:24] brightness
  output logic [lpdm_pkg::M_DATA_W-1:0]     m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [lpdm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lpdm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lpdm_pkg::*;

  // Only indexes an 8-bit field can reach get storage.
  localparam int STORE_DEPTH = (LED_COUNT < IDX_SPAN) ? LED_COUNT : IDX_SPAN;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W + 1)'(STORE_DEPTH);

  // Configuration registers; steps keep only the low byte, which is all
  // that matters for 8-bit wrapped channels.
  logic [DIV_W-1:0] div_eff;
  logic [CH_W-1:0]  hue_base;
  logic [CH_W-1:0]  hue_step;
  logic [CH_W-1:0]  sat_top;
  logic [CH_W-1:0]  sat_step;
  logic [CH_W-1:0]  bright_base;
  logic [CH_W-1:0]  bright_step;

  // A zero divider behaves as one, so the fix is applied on the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_eff     <= DIV_RESET;
      hue_base    <= HUE_BASE_RESET;
      hue_step    <= STEP_RESET;
      sat_top     <= SAT_TOP_RESET;
      sat_step    <= STEP_RESET;
      bright_base <= BRIGHT_BASE_RESET;
      bright_step <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_LEVEL_DIVIDER: div_eff <= (cfg_wdata[DIV_W-1:0] == '0) ? DIV_ONE
                                                                   : cfg_wdata[DIV_W-1:0];
        REG_HUE_BASE:      hue_base    <= cfg_wdata[CH_W-1:0];
        REG_HUE_STEP:      hue_step    <= cfg_wdata[CH_W-1:0];
        REG_SAT_TOP:       sat_top     <= cfg_wdata[CH_W-1:0];
        REG_SAT_STEP:      sat_step    <= cfg_wdata[CH_W-1:0];
        REG_BRIGHT_BASE:   bright_base <= cfg_wdata[CH_W-1:0];
        REG_BRIGHT_STEP:   bright_step <= cfg_wdata[CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input unpacking.
  logic [IDX_W-1:0]  in_idx;
  logic [MAG_W-1:0]  in_mag;
  logic [ADDR_W-1:0] in_addr;
  logic              accept;

  assign in_idx  = s_axis_tdata[IDX_W-1:0];
  assign in_mag  = s_axis_tdata[S_DATA_W-1:IDX_W];
  assign in_addr = in_idx[ADDR_W-1:0];

  // Peak update stage registers.
  logic              a_valid;
  logic [IDX_W-1:0]  a_idx;
  logic [MAG_W-1:0]  a_mag;
  logic [ADDR_W-1:0] a_addr;
  logic              a_in_range;
  logic [PEAK_W-1:0] a_rd;
  logic              a_vb;
  logic              a_fwd;
  logic [PEAK_W-1:0] a_fwd_peak;
  logic              a_ready;
  logic              a_write;

  // Held-peak store and its valid bits.
  logic [PEAK_W-1:0]      peak_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] peak_vld;

  // Divider handshake.
  logic              div_in_ready;
  logic              div_out_valid;
  logic              div_out_ready;
  logic [PEAK_W-1:0] div_level;
  logic [IDX_W-1:0]  div_tag;

  assign a_ready       = !a_valid || div_in_ready;
  assign accept        = s_axis_tvalid && a_ready;
  assign s_axis_tready = a_ready;

  // New peak: forwarded or stored old peak, replaced by a sample with a clear top bit
  // at or above it, clamped, then lowered by PEAK_DECAY with a floor of zero.
  logic [PEAK_W-1:0]  old_peak;
  logic               take_sample;
  logic [MAG_W-1:0]   cand;
  logic [CLAMP_W-1:0] clamped;
  logic [CLAMP_W-1:0] decayed;
  logic [PEAK_W-1:0]  a_new_peak;

  always_comb begin
    if (!a_in_range) begin
      old_peak = '0;
    end else if (a_fwd) begin
      old_peak = a_fwd_peak;
    end else if (a_vb) begin
      old_peak = a_rd;
    end else begin
      old_peak = '0;
    end
    take_sample = !a_mag[MAG_W-1] && (a_mag >= MAG_W'(old_peak));
    cand        = take_sample ? a_mag : MAG_W'(old_peak);
    clamped     = (cand > MAG_W'(PEAK_CLAMP)) ? PEAK_CLAMP : cand[CLAMP_W-1:0];
    decayed     = (clamped > PEAK_DECAY) ? (clamped - PEAK_DECAY) : '0;
    a_new_peak  = decayed[PEAK_W-1:0];
  end

  assign a_write = a_valid && div_in_ready && a_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  // Capture the item and read the store; flag a same-LED item that is
  // leaving this stage at the same edge so its result is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_idx      <= in_idx;
      a_mag      <= in_mag;
      a_addr     <= in_addr;
      a_in_range <= ({1'b0, in_idx} < DEPTH_LIM);
      a_vb       <= peak_vld[in_addr];
      a_fwd      <= a_valid && a_in_range && (a_idx == in_idx);
      a_fwd_peak <= a_new_peak;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_rd <= peak_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_write) begin
      peak_mem[a_addr] <= a_new_peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_vld <= '0;
    end else if (a_write) begin
      peak_vld[a_addr] <= 1'b1;
    end
  end

  // Level = peak / divider.
  lpdm_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (div_in_ready),
    .in_peak   (a_new_peak),
    .in_tag    (a_idx),
    .divisor   (div_eff),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .out_level (div_level),
    .out_tag   (div_tag)
  );

  // Color stage; only the low byte of level and step reach an 8-bit channel,
  // so each product is kept to one byte.
  logic [CH_W-1:0] lv8;
  logic [CH_W-1:0] prod_hue;
  logic [CH_W-1:0] prod_sat;
  logic [CH_W-1:0] prod_bri;
  logic [CH_W-1:0] hue_next;
  logic [CH_W-1:0] sat_next;
  logic [CH_W-1:0] bri_next;

  always_comb begin
    lv8      = div_level[CH_W-1:0];
    prod_hue = lv8 * hue_step;
    prod_sat = lv8 * sat_step;
    prod_bri = lv8 * bright_step;
    hue_next = hue_base + prod_hue;
    sat_next = sat_top - prod_sat;
    bri_next = bright_base + prod_bri;
  end

  logic             o_valid;
  logic [IDX_W-1:0] o_idx;
  logic [CH_W-1:0]  o_hue;
  logic [CH_W-1:0]  o_sat;
  logic [CH_W-1:0]  o_bri;

  assign div_out_ready = !o_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (div_out_ready) begin
      o_valid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_out_ready) begin
      o_idx <= div_tag;
      o_hue <= hue_next;
      o_sat <= sat_next;
      o_bri <= bri_next;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {o_bri, o_sat, o_hue, o_idx};

  // A decayed peak never exceeds the clamp minus the decay.
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> (a_new_peak <= PEAK_MAX))
    else $error("held peak above its decayed maximum");

  // Forwarding is only ever set up for an in-range LED.
  a_fwd_in_range: assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_fwd) |-> a_in_range)
    else $error("peak forwarded to an out-of-range LED");

  // The level can never exceed the largest peak.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    div_out_valid |-> (div_level <= PEAK_MAX))
    else $error("divider level out of range");

endmodule
